>>> sv/lbwd_pkg.sv
// ----------------------------------------------------------------------------
// lbwd_pkg
// types and constants shared by the low-bit weight dequantizer modules
// ----------------------------------------------------------------------------
package lbwd_pkg;

	typedef struct packed {
		logic [15:0] scale_bits;
		logic [7:0]  packed_byte;
		logic        final_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value_bits;
		logic        run_last;
		logic        tensor_last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] d;
		logic        is_nan;
		logic        is_inf;
		logic        is_zero;
	} scale_t;

	localparam int unsigned LANES = 8;
	localparam logic [0:0] FMT_ONE_BIT = 1'b0;
	localparam logic [0:0] FMT_TWO_BIT = 1'b1;
	localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
	localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
	localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
	localparam logic [7:0] HALF_SUB_EXP = 8'd113;
	localparam logic [7:0] EXP_BIAS_DIFF = 8'd112;
	localparam logic [1:0] ADDR_CODE_FORMAT = 2'd0;

endpackage

>>> sv/low_bit_weight_dequantizer_unit.sv
// ----------------------------------------------------------------------------
// low_bit_weight_dequantizer_unit
// expands packed 1-bit or 2-bit weight codes into binary32 weights
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_item) carries one packed byte, its
// binary16 block scale and a final marker. Eight lanes convert all codes of
// the byte in parallel into a result buffer; the output channel
// (out_valid/out_stall/out_item) then gives one binary32 weight per transfer,
// lowest code first, 8 in one-bit format and 4 in two-bit format.
// The first result appears in the cycle after the input transfer.
// The single output port sets the pace: the next byte is taken in the
// cycle the last result of the current one leaves, so the output stays
// busy without gaps.
// Reset marks the buffer empty and sets code_format to one-bit format.
// An output stall holds the current result and, once the buffer is full,
// stalls the input. code_format is at APB address 0.
// ----------------------------------------------------------------------------
module low_bit_weight_dequantizer_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lbwd_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lbwd_pkg::out_item_t  out_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import lbwd_pkg::*;

	logic fmt_q;
	scale_t scale;
	logic [7:0][31:0] lane_values;
	logic busy;
	logic load;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_CODE_FORMAT) ? {31'd0, fmt_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_ONE_BIT;
		end else if (psel && penable && pwrite && paddr == ADDR_CODE_FORMAT) begin
			fmt_q <= pwdata[0];
		end
	end

	lbwd_widen u_widen (
		.half  (in_item.scale_bits),
		.scale (scale)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic [1:0] code;
		assign code = (fmt_q == FMT_TWO_BIT) ? in_item.packed_byte[(2*(g%4)) +: 2]
			: {1'b0, in_item.packed_byte[g]};
		lbwd_lane u_lane (
			.scale (scale),
			.fmt   (fmt_q),
			.code  (code),
			.value (lane_values[g])
		);
	end

	assign in_stall = busy;
	assign load = in_valid && !busy;

	lbwd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.lane_values (lane_values),
		.load_fmt    (fmt_q),
		.load_final  (in_item.final_byte),
		.busy        (busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall) else $error("input taken under stall");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid) else $error("no output after input transfer");
	a_first_result: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> !out_item.run_last) else $error("byte ended early");

endmodule

>>> sv/lbwd_widen.sv
// ----------------------------------------------------------------------------
// lbwd_widen
// binary16 to binary32 scale conversion with class flags
// ----------------------------------------------------------------------------
module lbwd_widen (
	input  logic [15:0]    half,
	output lbwd_pkg::scale_t scale
);
	import lbwd_pkg::*;

	logic [4:0] ex;
	logic [9:0] fr;
	logic [3:0] lz;
	logic [9:0] frn;
	logic [31:0] d;

	assign ex = half[14:10];
	assign fr = half[9:0];

	// leading zero count of the subnormal fraction
	always_comb begin
		lz = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (fr[i]) begin
				lz = 4'(9 - i);
			end
		end
	end

	always_comb begin
		frn = 10'(fr << (lz + 4'd1));
		if (ex == 5'd0) begin
			if (fr == 10'd0) begin
				d = {half[15], 31'd0};
			end else begin
				d = {half[15], HALF_SUB_EXP - 8'(lz) - 8'd1, frn, 13'd0};
			end
		end else if (ex == 5'h1F) begin
			d = {half[15], 8'hFF, fr, 13'd0};
		end else begin
			d = {half[15], 8'(ex) + EXP_BIAS_DIFF, fr, 13'd0};
		end
	end

	assign scale.d = d;
	assign scale.is_nan = (ex == 5'h1F) && (fr != 10'd0);
	assign scale.is_inf = (ex == 5'h1F) && (fr == 10'd0);
	assign scale.is_zero = (ex == 5'd0) && (fr == 10'd0);

endmodule

>>> sv/lbwd_lane.sv
// ----------------------------------------------------------------------------
// lbwd_lane
// one code to one binary32 weight
// ----------------------------------------------------------------------------
module lbwd_lane (
	input  lbwd_pkg::scale_t scale,
	input  logic             fmt,
	input  logic [1:0]       code,
	output logic [31:0]      value
);
	import lbwd_pkg::*;

	always_comb begin
		if (fmt == FMT_ONE_BIT) begin
			value = code[0] ? scale.d : (scale.d ^ SIGN_BIT);
		end else if (scale.is_nan) begin
			value = scale.d | QUIET_BIT;
		end else begin
			case (code)
				2'd0: value = scale.d ^ SIGN_BIT;
				2'd1: value = scale.is_inf ? DEFAULT_NAN : (scale.d & SIGN_BIT);
				2'd2: value = scale.d;
				default: value = (scale.is_inf || scale.is_zero) ? scale.d
					: scale.d + 32'h0080_0000;
			endcase
		end
	end

endmodule

>>> sv/lbwd_merge.sv
// ----------------------------------------------------------------------------
// lbwd_merge
// holds the lane results of one byte and serializes them to the output
// ----------------------------------------------------------------------------
module lbwd_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [7:0][31:0]     lane_values,
	input  logic                 load_fmt,
	input  logic                 load_final,
	output logic                 busy,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lbwd_pkg::out_item_t  out_item
);
	import lbwd_pkg::*;

	logic [7:0][31:0] vals_q;
	logic [2:0] idx_q;
	logic [2:0] last_idx_q;
	logic final_q;
	logic valid_q;
	logic is_last;
	logic take;

	assign is_last = idx_q == last_idx_q;
	assign take = valid_q && !out_stall;
	assign busy = valid_q && !(take && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= 3'd0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
			if (is_last) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vals_q <= lane_values;
			last_idx_q <= (load_fmt == FMT_TWO_BIT) ? 3'd3 : 3'd7;
			final_q <= load_final;
		end
	end

	assign out_valid = valid_q;
	assign out_item.value_bits = vals_q[idx_q];
	assign out_item.run_last = is_last;
	assign out_item.tensor_last = is_last && final_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q <= last_idx_q) else $error("index past last");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy) else $error("load while busy");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !is_last && !load) |=> idx_q == $past(idx_q) + 3'd1)
		else $error("index did not advance");

endmodule
